[rtl/char_lcd_command_formatter_assert.svh]
// Assertion helpers for the formatter controller.
`ifndef CHAR_LCD_COMMAND_FORMATTER_ASSERT_SVH
`define CHAR_LCD_COMMAND_FORMATTER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("char lcd formatter: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("char lcd formatter: next-cycle check failed");

`endif

[rtl/clcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

  // Request codes
  localparam logic [2:0] CMD_BYTE    = 3'd0;
  localparam logic [2:0] CMD_CHAR    = 3'd1;
  localparam logic [2:0] CMD_LOCATE  = 3'd2;
  localparam logic [2:0] CMD_DISPLAY = 3'd3;
  localparam logic [2:0] CMD_CURSOR  = 3'd4;
  localparam logic [2:0] CMD_INT     = 3'd5;

  // Mode argument codes
  localparam logic [1:0] MODE_OFF       = 2'd0;
  localparam logic [1:0] MODE_ON        = 2'd1;
  localparam logic [1:0] MODE_BLINK_ON  = 2'd2;
  localparam logic [1:0] MODE_BLINK_OFF = 2'd3;

  // Display-control byte and its bit masks
  localparam logic [7:0] DC_RESET       = 8'b0000_1000;
  localparam logic [7:0] DC_DISP_SET    = 8'b0000_0100;
  localparam logic [7:0] DC_DISP_CLR    = 8'b1111_1011;
  localparam logic [7:0] DC_CURSOR_SET  = 8'b0000_0010;
  localparam logic [7:0] DC_CURSOR_CLR  = 8'b1111_1101;
  localparam logic [7:0] DC_BLINK_SET   = 8'b0000_0001;
  localparam logic [7:0] DC_BLINK_CLR   = 8'b1111_1110;

  // Character codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // Register-select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Number conversion sizes
  localparam int MAG_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = 5;
  localparam int DIG_CNT_W  = 4;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_SHIFT,
    DP_MINUS,
    DP_SKIP,
    DP_DIGIT
  } dp_op_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_HI,
    OUT_LO
  } out_op_e;

  typedef struct packed {
    dp_op_e  op;
    out_op_e out_op;
    logic    last_digit;
  } dp_ctrl_t;

  typedef struct packed {
    logic neg;
    logic top_zero;
    logic byte_last;
  } dp_stat_t;

  // Set-DDRAM-address base of each panel row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

[rtl/clcd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module clcd_datapath
  import clcd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_ctrl_t          ctrl_i,
  input  wire logic [2:0]        cmd_i,
  input  wire logic [7:0]        byte_value_i,
  input  wire logic [1:0]        row_i,
  input  wire logic [4:0]        col_i,
  input  wire logic [1:0]        mode_arg_i,
  input  wire logic signed [31:0] number_i,
  output dp_stat_t               stat_o,
  output logic                   reg_select_o,
  output logic [3:0]             nibble_o,
  output logic                   last_o
);

  logic [7:0]       disp_ctrl_q, disp_ctrl_d;
  logic [7:0]       byte_q, accept_byte;
  logic             byte_rs_q, accept_rs;
  logic             byte_last_q;
  logic             neg_q;
  logic [MAG_W-1:0] mag_q;
  logic [BCD_W-1:0] bcd_q, bcd_adj;
  logic [3:0]       top_digit;
  logic             out_rs_q;
  logic [3:0]       out_nibble_q;
  logic             out_last_q;

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // Add three to every BCD digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Decode the request into its first byte and the new display control
  always_comb begin
    disp_ctrl_d = disp_ctrl_q;
    accept_byte = byte_value_i;
    accept_rs   = RS_CMD;
    unique case (cmd_i)
      CMD_BYTE: begin
        accept_byte = byte_value_i;
      end
      CMD_CHAR: begin
        accept_rs = RS_DATA;
      end
      CMD_LOCATE: begin
        accept_byte = row_base(row_i) + {3'b000, col_i};
      end
      CMD_DISPLAY: begin
        if (mode_arg_i == MODE_OFF) begin
          disp_ctrl_d = disp_ctrl_q & DC_DISP_CLR;
        end else if (mode_arg_i == MODE_ON) begin
          disp_ctrl_d = disp_ctrl_q | DC_DISP_SET;
        end
        accept_byte = disp_ctrl_d;
      end
      CMD_CURSOR: begin
        unique case (mode_arg_i)
          MODE_OFF:       disp_ctrl_d = disp_ctrl_q & DC_CURSOR_CLR;
          MODE_ON:        disp_ctrl_d = disp_ctrl_q | DC_CURSOR_SET;
          MODE_BLINK_ON:  disp_ctrl_d = disp_ctrl_q | DC_BLINK_SET;
          default:        disp_ctrl_d = disp_ctrl_q & DC_BLINK_CLR;
        endcase
        accept_byte = disp_ctrl_d;
      end
      CMD_INT: begin
        accept_byte = ASCII_MINUS;
        accept_rs   = RS_DATA;
      end
      default: begin
        disp_ctrl_d = disp_ctrl_q;
      end
    endcase
  end

  // Hold the display-control byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_ctrl_q <= DC_RESET;
    end else if (ctrl_i.op == DP_ACCEPT) begin
      disp_ctrl_q <= disp_ctrl_d;
    end
  end

  // Working byte, magnitude and BCD registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      DP_ACCEPT: begin
        byte_q      <= accept_byte;
        byte_rs_q   <= accept_rs;
        byte_last_q <= 1'b1;
        neg_q       <= number_i[MAG_W-1];
        mag_q       <= number_i[MAG_W-1] ? (MAG_W'(0) - MAG_W'(number_i))
                                         : MAG_W'(number_i);
        bcd_q       <= '0;
      end
      DP_SHIFT: begin
        bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[MAG_W-1]};
        mag_q <= {mag_q[MAG_W-2:0], 1'b0};
      end
      DP_MINUS: begin
        byte_q      <= ASCII_MINUS;
        byte_rs_q   <= RS_DATA;
        byte_last_q <= 1'b0;
      end
      DP_SKIP: begin
        bcd_q <= {bcd_q[BCD_W-5:0], 4'h0};
      end
      DP_DIGIT: begin
        byte_q      <= ASCII_ZERO + {4'h0, top_digit};
        byte_rs_q   <= RS_DATA;
        byte_last_q <= ctrl_i.last_digit;
        bcd_q       <= {bcd_q[BCD_W-5:0], 4'h0};
      end
      default: begin
        byte_q <= byte_q;
      end
    endcase
  end

  // Output register: one nibble per beat
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.out_op)
      OUT_HI: begin
        out_rs_q     <= byte_rs_q;
        out_nibble_q <= byte_q[7:4];
        out_last_q   <= 1'b0;
      end
      OUT_LO: begin
        out_rs_q     <= byte_rs_q;
        out_nibble_q <= byte_q[3:0];
        out_last_q   <= byte_last_q;
      end
      default: begin
        out_last_q <= out_last_q;
      end
    endcase
  end

  assign stat_o.neg       = neg_q;
  assign stat_o.top_zero  = (top_digit == 4'h0);
  assign stat_o.byte_last = byte_last_q;

  assign reg_select_o = out_rs_q;
  assign nibble_o     = out_nibble_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

[rtl/clcd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_command_formatter_assert.svh"

module clcd_ctrl
  import clcd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] cmd_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_stat_t   stat_i,
  output dp_ctrl_t        ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_MINUS,
    ST_DIGIT,
    ST_HI,
    ST_LO
  } state_e;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(MAG_W - 1);
  localparam logic [DIG_CNT_W-1:0] DIG_START = DIG_CNT_W'(NUM_DIGITS);
  localparam logic [DIG_CNT_W-1:0] DIG_ONE   = DIG_CNT_W'(1);

  state_e                 state_q, state_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic                   started_q, started_d;
  logic                   out_valid_q, out_valid_d;
  logic                   in_accept;
  logic                   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Sequence one request: convert integers and skip their leading zeros, send bytes
  always_comb begin
    state_d           = state_q;
    bit_cnt_d         = bit_cnt_q;
    dig_cnt_d         = dig_cnt_q;
    started_d         = started_q;
    ctrl_o.op         = DP_NONE;
    ctrl_o.out_op     = OUT_NONE;
    ctrl_o.last_digit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ctrl_o.op = DP_ACCEPT;
          bit_cnt_d = '0;
          if (cmd_i == CMD_INT) begin
            state_d = ST_CONV;
          end else if (cmd_i == CMD_BYTE || cmd_i == CMD_CHAR || cmd_i == CMD_LOCATE ||
                       cmd_i == CMD_DISPLAY || cmd_i == CMD_CURSOR) begin
            state_d = ST_HI;
          end
        end
      end
      ST_CONV: begin
        ctrl_o.op = DP_SHIFT;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BIT_LAST) begin
          dig_cnt_d = DIG_START;
          started_d = 1'b0;
          state_d   = stat_i.neg ? ST_MINUS : ST_DIGIT;
        end
      end
      ST_MINUS: begin
        ctrl_o.op = DP_MINUS;
        state_d   = ST_HI;
      end
      ST_DIGIT: begin
        dig_cnt_d = dig_cnt_q - 1'b1;
        if (!started_q && stat_i.top_zero && (dig_cnt_q != DIG_ONE)) begin
          ctrl_o.op = DP_SKIP;
        end else begin
          ctrl_o.op         = DP_DIGIT;
          ctrl_o.last_digit = (dig_cnt_q == DIG_ONE);
          started_d         = 1'b1;
          state_d           = ST_HI;
        end
      end
      ST_HI: begin
        if (out_free) begin
          ctrl_o.out_op = OUT_HI;
          state_d       = ST_LO;
        end
      end
      ST_LO: begin
        if (out_free) begin
          ctrl_o.out_op = OUT_LO;
          state_d       = stat_i.byte_last ? ST_IDLE : ST_DIGIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold valid until the beat is taken; set it on each nibble load
  always_comb begin
    if (ctrl_o.out_op != OUT_NONE) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CLCD_ASSERT_NOW(a_digit_cnt_live, clk_i, rst_ni, state_q == ST_DIGIT, dig_cnt_q != '0)
  `CLCD_ASSERT_NEXT(a_hi_then_lo, clk_i, rst_ni, state_q == ST_HI && out_free, state_q == ST_LO && out_valid_q)
  `CLCD_ASSERT_NEXT(a_conv_end, clk_i, rst_ni, state_q == ST_CONV && bit_cnt_q == BIT_LAST, state_q == ST_MINUS || state_q == ST_DIGIT)

endmodule

`default_nettype wire

[rtl/char_lcd_command_formatter.sv]
// Byte requests (command, character, locate, display, cursor): two nibble beats; the byte is
// registered at accept, then each nibble goes to the output register, and the controller
// returns to idle for the next request. Integer requests: accept, shift-add-3 over all 32 bits,
// a skip per leading zero (up to 9), then per character incl. the minus sign a byte load and
// two beats: up to 22 beats. Output stalls add cycles; the next request is taken while the
// final beat still waits. Reset: controller idle, no beat valid, display-control byte 0x08.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_command_formatter
  import clcd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [7:0]         byte_value_i,
  input  wire logic [1:0]         row_i,
  input  wire logic [4:0]         col_i,
  input  wire logic [1:0]         mode_arg_i,
  input  wire logic signed [31:0] number_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    reg_select_o,
  output logic [3:0]              nibble_o,
  output logic                    last_o
);

  dp_ctrl_t dp_ctrl;
  dp_stat_t dp_stat;

  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .ctrl_o      (dp_ctrl)
  );

  clcd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (dp_ctrl),
    .cmd_i        (cmd_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .mode_arg_i   (mode_arg_i),
    .number_i     (number_i),
    .stat_o       (dp_stat),
    .reg_select_o (reg_select_o),
    .nibble_o     (nibble_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[verif/tb_char_lcd_command_formatter.sv]
`timescale 1ns / 1ps

module tb_char_lcd_command_formatter;
  import clcd_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PRESSURE_ITEMS = 30;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int IDLE_LIMIT = 5000;

  // Codes the block does not decode; they must produce no beats
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } lcd_transfer_t;

  // Predicts the nibble transfers of each request and checks the bus side
  class lcd_transfer_scoreboard;
    lcd_transfer_t pending_transfers[$];
    logic [7:0]    disp_ctrl;
    int            errors;
    int            requests_noted;
    int            beats_checked;

    function new();
      disp_ctrl      = DC_RESET;
      errors         = 0;
      requests_noted = 0;
      beats_checked  = 0;
    endfunction

    function int pending();
      return pending_transfers.size();
    endfunction

    // Queue one byte as two beats, high nibble first
    function void push_byte(logic rs, logic [7:0] b);
      lcd_transfer_t t;
      t.rs   = rs;
      t.last = 1'b0;
      t.nib  = b[7:4];
      pending_transfers.push_back(t);
      t.nib  = b[3:0];
      pending_transfers.push_back(t);
    endfunction

    function logic [7:0] panel_address(logic [1:0] row, logic [4:0] col);
      logic [7:0] base;
      case (row)
        2'd0:    base = 8'h80;
        2'd1:    base = 8'hC0;
        2'd2:    base = 8'h94;
        default: base = 8'hD4;
      endcase
      return base + {3'b000, col};
    endfunction

    function void note_request(logic [2:0] cmd, logic [7:0] bv, logic [1:0] row,
                               logic [4:0] col, logic [1:0] mode, logic [31:0] num);
      int         start_size;
      int         cnt;
      logic [31:0] mag;
      logic [7:0] digits[10];
      start_size = pending_transfers.size();
      requests_noted++;
      case (cmd)
        CMD_BYTE:   push_byte(RS_CMD, bv);
        CMD_CHAR:   push_byte(RS_DATA, bv);
        CMD_LOCATE: push_byte(RS_CMD, panel_address(row, col));
        CMD_DISPLAY: begin
          // Blink codes leave the byte alone but it is still sent
          if (mode == MODE_OFF) disp_ctrl = disp_ctrl & DC_DISP_CLR;
          else if (mode == MODE_ON) disp_ctrl = disp_ctrl | DC_DISP_SET;
          push_byte(RS_CMD, disp_ctrl);
        end
        CMD_CURSOR: begin
          case (mode)
            MODE_OFF:      disp_ctrl = disp_ctrl & DC_CURSOR_CLR;
            MODE_ON:       disp_ctrl = disp_ctrl | DC_CURSOR_SET;
            MODE_BLINK_ON: disp_ctrl = disp_ctrl | DC_BLINK_SET;
            default:       disp_ctrl = disp_ctrl & DC_BLINK_CLR;
          endcase
          push_byte(RS_CMD, disp_ctrl);
        end
        CMD_INT: begin
          // Magnitude as unsigned so the most negative value converts cleanly
          mag = num;
          if (num[31]) begin
            push_byte(RS_DATA, ASCII_MINUS);
            mag = 32'd0 - num;
          end
          cnt = 0;
          do begin
            digits[cnt] = ASCII_ZERO + 8'(mag % 32'd10);
            cnt = cnt + 1;
            mag = mag / 32'd10;
          end while (mag != 0 && cnt < 10);
          while (cnt > 0) begin
            cnt = cnt - 1;
            push_byte(RS_DATA, digits[cnt]);
          end
        end
        default: ;
      endcase
      if (pending_transfers.size() > start_size)
        pending_transfers[pending_transfers.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(logic rs, logic [3:0] nib, logic last);
      lcd_transfer_t got;
      lcd_transfer_t want;
      got.rs   = rs;
      got.nib  = nib;
      got.last = last;
      beats_checked++;
      if (pending_transfers.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual rs=%0b nibble=%h last=%0b",
                 $time, rs, nib, last);
      end else begin
        want = pending_transfers.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: beat mismatch, expected rs=%0b nibble=%h last=%0b,",
                   $time, want.rs, want.nib, want.last,
                   " actual rs=%0b nibble=%h last=%0b", rs, nib, last);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         cmd_i = CMD_BYTE;
  logic [7:0]         byte_value_i = 8'h00;
  logic [1:0]         row_i = 2'd0;
  logic [4:0]         col_i = 5'd0;
  logic [1:0]         mode_arg_i = MODE_OFF;
  logic signed [31:0] number_i = 32'sd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               reg_select_o;
  logic [3:0]         nibble_o;
  logic               last_o;

  lcd_transfer_scoreboard sb;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_epoch = 0;
  int seen_epoch = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  char_lcd_command_formatter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .mode_arg_i   (mode_arg_i),
    .number_i     (number_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reg_select_o (reg_select_o),
    .nibble_o     (nibble_o),
    .last_o       (last_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Check accepted beats, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat(reg_select_o, nibble_o, last_o);
    if (hold_epoch != seen_epoch) begin
      seen_epoch = hold_epoch;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stop a hung run: count cycles in which neither side moves a beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one request after an optional gap and hold it until accepted
  task automatic send_req(input logic [2:0] cmd, input logic [7:0] bv, input logic [1:0] row,
                          input logic [4:0] col, input logic [1:0] mode,
                          input logic [31:0] num);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    byte_value_i <= bv;
    row_i        <= row;
    col_i        <= col;
    mode_arg_i   <= mode;
    number_i     <= num;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, bv, row, col, mode, num);
  endtask

  // Random request; mostly real operations, a few unused codes as noise
  task automatic send_random(output bit counted);
    logic [2:0]  cmd;
    logic [31:0] num;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 8) cmd = pick[0] ? CMD_UNUSED_7 : CMD_UNUSED_6;
    else cmd = 3'($urandom_range(5));
    // Spread the magnitude over every digit count
    case ($urandom_range(2))
      0:       num = $urandom;
      1:       num = $urandom_range(999);
      default: num = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) num = 32'd0 - num;
    send_req(cmd, 8'($urandom), 2'($urandom), 5'($urandom), 2'($urandom), num);
    counted = (cmd != CMD_UNUSED_6) && (cmd != CMD_UNUSED_7);
  endtask

  task automatic run_random(input int n);
    int counted;
    bit hit;
    counted = 0;
    while (counted < n) begin
      send_random(hit);
      if (hit) counted++;
    end
  endtask

  // Drop valid and wait for every predicted beat
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every operation, special cases
    send_req(CMD_BYTE,    8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_BYTE,    8'hFF, 2'd3, 5'd31, MODE_BLINK_OFF, 32'hFFFF_FFFF);
    send_req(CMD_CHAR,    8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_CHAR,    8'hFF, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_CHAR,    8'h5A, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_LOCATE,  8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_LOCATE,  8'h00, 2'd1, 5'd19, MODE_OFF, 32'd0);
    send_req(CMD_LOCATE,  8'h00, 2'd2, 5'd7,  MODE_OFF, 32'd0);
    send_req(CMD_LOCATE,  8'h00, 2'd3, 5'd31, MODE_OFF, 32'd0);
    send_req(CMD_DISPLAY, 8'h00, 2'd0, 5'd0,  MODE_ON, 32'd0);
    send_req(CMD_DISPLAY, 8'h00, 2'd0, 5'd0,  MODE_BLINK_ON, 32'd0);
    send_req(CMD_DISPLAY, 8'h00, 2'd0, 5'd0,  MODE_BLINK_OFF, 32'd0);
    send_req(CMD_DISPLAY, 8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_CURSOR,  8'h00, 2'd0, 5'd0,  MODE_ON, 32'd0);
    send_req(CMD_CURSOR,  8'h00, 2'd0, 5'd0,  MODE_BLINK_ON, 32'd0);
    send_req(CMD_CURSOR,  8'h00, 2'd0, 5'd0,  MODE_BLINK_OFF, 32'd0);
    send_req(CMD_CURSOR,  8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_INT,     8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    send_req(CMD_INT,     8'h00, 2'd0, 5'd0,  MODE_OFF, 32'hFFFF_FFFF);
    send_req(CMD_INT,     8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd7);
    send_req(CMD_INT,     8'h00, 2'd0, 5'd0,  MODE_OFF, 32'h7FFF_FFFF);
    send_req(CMD_INT,     8'h00, 2'd0, 5'd0,  MODE_OFF, 32'h8000_0000);
    send_req(CMD_INT,     8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd1000000000);
    send_req(CMD_INT,     8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0 - 32'd987654321);
    send_req(CMD_UNUSED_6, 8'hFF, 2'd3, 5'd31, MODE_BLINK_OFF, 32'hFFFF_FFFF);
    send_req(CMD_UNUSED_7, 8'h00, 2'd0, 5'd0,  MODE_OFF, 32'd0);
    drain();

    // Random phases under different idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      run_random(ITEMS_PER_PHASE);
      drain();
      if (phase == 1) begin
        // Hold the output side off long enough to back up the input
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_epoch <= hold_epoch + 1;
        run_random(PRESSURE_ITEMS);
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests over all six operations, unused codes and idling mixes,",
             sb.requests_noted);
    $display("including a long output hold; %0d nibble beats checked.", sb.beats_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[char_lcd_command_formatter.f]
+incdir+rtl
rtl/clcd_pkg.sv
rtl/clcd_datapath.sv
rtl/clcd_ctrl.sv
rtl/char_lcd_command_formatter.sv
verif/tb_char_lcd_command_formatter.sv
